### rtl/frpm_pkg.sv
package frpm_pkg;

	// field widths
	localparam int SAMPLE_W = 16;
	localparam int PEAK_W   = 16;
	localparam int LEN_W    = 13;
	localparam int RMS_W    = 24;
	localparam int SQ_W     = 2 * PEAK_W;

	// 8 fraction bits on the root means 16 on the radicand
	localparam int FRAC_SHIFT = 16;

	// mean square times 2^16 is at most 2^46 for any frame length
	localparam int Q_W = 47;

	// square root unit
	localparam int ROOT_W  = RMS_W;
	localparam int RAD_W   = 2 * ROOT_W;
	localparam int SREM_W  = ROOT_W + 4;

	// defaults for the top level parameters
	localparam int MAX_FRAME_DEF  = 4096;
	localparam int FIFO_DEPTH_DEF = 2;

	typedef enum logic [1:0] {
		B_IDLE,
		B_DIV,
		B_SQRT,
		B_DONE
	} back_state_t;

endpackage

### rtl/frpm_front.sv
module frpm_front
	import frpm_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF,
	localparam int CNT_W = $clog2(MAX_FRAME + 1),
	localparam int SUM_W = SQ_W - 2 + CNT_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       frame_end,
	output logic                       fq_push,
	input  logic                       fq_full,
	output logic [SUM_W-1:0]           fq_sum,
	output logic [PEAK_W-1:0]          fq_peak,
	output logic [CNT_W-1:0]           fq_len
);

	logic                accept;
	logic [PEAK_W-1:0]   mag;
	logic [SAMPLE_W-1:0] sample_u;

	logic                valid_s1;
	logic [PEAK_W-1:0]   mag_s1;
	logic                last_s1;

	logic [SUM_W-1:0]    sum_q;
	logic [PEAK_W-1:0]   peak_q;
	logic [CNT_W-1:0]    cnt_q;

	logic [SQ_W-1:0]     sq;
	logic [SUM_W-1:0]    sum_nxt;
	logic [PEAK_W-1:0]   peak_nxt;
	logic [CNT_W-1:0]    cnt_nxt;
	logic                close;
	logic                fire;

	// magnitude; the most negative code maps to 0x8000 = 32768
	assign sample_u = $unsigned(sample);
	assign mag      = sample_u[SAMPLE_W-1] ? PEAK_W'(~sample_u + 1'b1) : PEAK_W'(sample_u);

	assign sq       = SQ_W'(mag_s1) * SQ_W'(mag_s1);
	assign sum_nxt  = sum_q + SUM_W'(sq);
	assign peak_nxt = (mag_s1 > peak_q) ? mag_s1 : peak_q;
	assign cnt_nxt  = cnt_q + 1'b1;
	assign close    = last_s1 || (cnt_nxt == CNT_W'(MAX_FRAME));

	assign fire    = valid_s1 && (!close || !fq_full);
	assign full    = valid_s1 && !fire;
	assign accept  = push && !full;
	assign fq_push = valid_s1 && close && !fq_full;
	assign fq_sum  = sum_nxt;
	assign fq_peak = peak_nxt;
	assign fq_len  = cnt_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !fire);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mag_s1  <= mag;
			last_s1 <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			peak_q <= '0;
			cnt_q  <= '0;
		end else if (fire) begin
			if (close) begin
				sum_q  <= '0;
				peak_q <= '0;
				cnt_q  <= '0;
			end else begin
				sum_q  <= sum_nxt;
				peak_q <= peak_nxt;
				cnt_q  <= cnt_nxt;
			end
		end
	end

	a_cnt_below_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CNT_W'(MAX_FRAME))
		else $error("frame count reached the frame limit without closing");

	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fq_push |=> (cnt_q == '0) && (sum_q == '0) && (peak_q == '0))
		else $error("accumulators not cleared after frame close");

	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> (valid_s1 && close && fq_full))
		else $error("full raised without a blocked frame close");

endmodule

### rtl/frpm_fifo.sv
module frpm_fifo
	import frpm_pkg::*;
#(
	parameter int WIDTH = 1,
	parameter int DEPTH = FIFO_DEPTH_DEF,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	output logic             full,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             empty
);

	// DEPTH must be a power of two, which the block does not check; pointers wrap on overflow
	logic [WIDTH-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/frpm_back.sv
module frpm_back
	import frpm_pkg::*;
#(
	parameter int MAX_FRAME = MAX_FRAME_DEF,
	localparam int CNT_W  = $clog2(MAX_FRAME + 1),
	localparam int SUM_W  = SQ_W - 2 + CNT_W,
	localparam int DIV_W  = SUM_W + FRAC_SHIFT,
	localparam int STEP_W = $clog2(DIV_W + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fq_empty,
	output logic              fq_pop,
	input  logic [SUM_W-1:0]  fq_sum,
	input  logic [PEAK_W-1:0] fq_peak,
	input  logic [CNT_W-1:0]  fq_len,
	output logic              empty,
	input  logic              pop,
	output logic [RMS_W-1:0]  rms_level,
	output logic [PEAK_W-1:0] peak_level,
	output logic [LEN_W-1:0]  frame_length
);

	back_state_t state_q, state_nxt;
	logic [STEP_W-1:0] step_q;
	logic              last_step;
	logic              load_out;

	// divider
	logic [DIV_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_diff;
	logic              qbit;
	logic [CNT_W-1:0]  rem_nxt;
	logic [DIV_W-1:0]  dvd_nxt;

	// square root
	logic [RAD_W-1:0]  rad_q;
	logic [SREM_W-1:0] srem_q;
	logic [ROOT_W-1:0] root_q;
	logic [SREM_W-1:0] srem_sh;
	logic [SREM_W-1:0] trial;
	logic              sbit;
	logic [SREM_W-1:0] srem_nxt;
	logic [ROOT_W-1:0] root_nxt;

	// frame record and result register
	logic [PEAK_W-1:0] pk_q;
	logic [CNT_W-1:0]  len_q;
	logic              out_valid_q;
	logic [RMS_W-1:0]  rms_q;
	logic [PEAK_W-1:0] pk_out_q;
	logic [CNT_W-1:0]  len_out_q;

	assign last_step = (step_q == STEP_W'(1));

	// restoring division, one quotient bit per cycle
	assign rem_sh   = {rem_q, dvd_q[DIV_W-1]};
	assign rem_diff = rem_sh - {1'b0, dsr_q};
	assign qbit     = (rem_sh >= {1'b0, dsr_q});
	assign rem_nxt  = qbit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
	assign dvd_nxt  = {dvd_q[DIV_W-2:0], qbit};

	// digit-by-digit root, one result bit per cycle
	assign srem_sh  = {srem_q[SREM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign sbit     = (srem_sh >= trial);
	assign srem_nxt = sbit ? (srem_sh - trial) : srem_sh;
	assign root_nxt = {root_q[ROOT_W-2:0], sbit};

	always_comb begin
		state_nxt = state_q;
		fq_pop    = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!fq_empty) begin
					fq_pop    = 1'b1;
					state_nxt = B_DIV;
				end
			end
			B_DIV: begin
				if (last_step) begin
					state_nxt = B_SQRT;
				end
			end
			B_SQRT: begin
				if (last_step) begin
					state_nxt = B_DONE;
				end
			end
			B_DONE: begin
				if (!out_valid_q || pop) begin
					load_out  = 1'b1;
					state_nxt = B_IDLE;
				end
			end
			default: begin
				state_nxt = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				B_IDLE: begin
					if (fq_pop) begin
						step_q <= STEP_W'(DIV_W);
					end
				end
				B_DIV: begin
					step_q <= last_step ? STEP_W'(ROOT_W) : step_q - 1'b1;
				end
				B_SQRT: begin
					step_q <= step_q - 1'b1;
				end
				default: begin
					step_q <= step_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (fq_pop) begin
					dvd_q <= {fq_sum, {FRAC_SHIFT{1'b0}}};
					rem_q <= '0;
					dsr_q <= fq_len;
					pk_q  <= fq_peak;
					len_q <= fq_len;
				end
			end
			B_DIV: begin
				dvd_q <= dvd_nxt;
				rem_q <= rem_nxt;
				if (last_step) begin
					rad_q  <= RAD_W'(dvd_nxt[Q_W-1:0]);
					srem_q <= '0;
					root_q <= '0;
				end
			end
			B_SQRT: begin
				rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
				srem_q <= srem_nxt;
				root_q <= root_nxt;
			end
			default: begin
				rad_q <= rad_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rms_q     <= root_q;
			pk_out_q  <= pk_q;
			len_out_q <= len_q;
		end
	end

	assign empty        = !out_valid_q;
	assign rms_level    = rms_q;
	assign peak_level   = pk_out_q;
	assign frame_length = LEN_W'(len_out_q);

	a_divisor_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == B_DIV) |-> (dsr_q != '0))
		else $error("division started with a zero frame length");

	a_step_live: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == B_DIV) || (state_q == B_SQRT)) |-> (step_q != '0))
		else $error("step counter ran out inside an iteration");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_valid_q && (state_q == B_IDLE)))
		else $error("finished result not placed in the output register");

endmodule

### rtl/frame_rms_peak_meter.sv
// Frame RMS and peak meter. Signed 16-bit samples go in through a queue-style port
// (push/full), one per clock while full is low; frame_end marks the last sample of a
// frame, and a frame that reaches MAX_FRAME samples closes on its own. For each frame
// one result comes out through a second queue-style port (empty/pop): rms_level =
// floor(sqrt(floor(sum of squares * 65536 / length))), i.e. the RMS with 8 fraction
// bits, plus the peak magnitude (-32768 counts as 32768) and the frame length.
// Samples are taken every cycle while full is low; the square-and-accumulate runs one
// stage behind the input register. A closed frame is parked in a small record queue
// and then worked off, one frame at a time, by a shared back end: a restoring divider
// with one quotient bit per cycle over a SUM_W + 16 bit dividend (59 bits at the
// default MAX_FRAME of 4096), a bit-per-cycle 24-bit square root and a hand-over.
// full rises only when a frame closes while the record queue is full, so in a steady
// stream frames shorter than a back-end pass will eventually back-pressure the input.
module frame_rms_peak_meter
	import frpm_pkg::*;
#(
	parameter int MAX_FRAME  = MAX_FRAME_DEF,
	parameter int FIFO_DEPTH = FIFO_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// sample side
	input  logic                       push,
	output logic                       full,
	input  logic signed [SAMPLE_W-1:0] sample,
	input  logic                       frame_end,
	// result side
	output logic                       empty,
	input  logic                       pop,
	output logic [RMS_W-1:0]           rms_level,
	output logic [PEAK_W-1:0]          peak_level,
	output logic [LEN_W-1:0]           frame_length
);

	// counter and sum widths follow the frame limit
	localparam int CNT_W = $clog2(MAX_FRAME + 1);
	localparam int SUM_W = SQ_W - 2 + CNT_W;
	localparam int REC_W = SUM_W + PEAK_W + CNT_W;

	// closed-frame record: front to record queue
	logic              fq_push;
	logic              fq_full;
	logic [SUM_W-1:0]  fq_sum_in;
	logic [PEAK_W-1:0] fq_peak_in;
	logic [CNT_W-1:0]  fq_len_in;

	// record queue to back end
	logic              fq_pop;
	logic              fq_empty;
	logic [REC_W-1:0]  fq_rd_data;
	logic [SUM_W-1:0]  fq_sum_out;
	logic [PEAK_W-1:0] fq_peak_out;
	logic [CNT_W-1:0]  fq_len_out;

	// front: magnitude, square, accumulate; one sample transaction per clock while full is low
	frpm_front #(
		.MAX_FRAME (MAX_FRAME)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.sample    (sample),
		.frame_end (frame_end),
		.fq_push   (fq_push),
		.fq_full   (fq_full),
		.fq_sum    (fq_sum_in),
		.fq_peak   (fq_peak_in),
		.fq_len    (fq_len_in)
	);

	// short record queue decouples accumulation from the slow divide/root
	frpm_fifo #(
		.WIDTH (REC_W),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fq_push),
		.wr_data ({fq_sum_in, fq_peak_in, fq_len_in}),
		.full    (fq_full),
		.rd_en   (fq_pop),
		.rd_data (fq_rd_data),
		.empty   (fq_empty)
	);

	assign {fq_sum_out, fq_peak_out, fq_len_out} = fq_rd_data;

	// back: mean square by long division, then integer square root, then result register
	frpm_back #(
		.MAX_FRAME (MAX_FRAME)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fq_empty     (fq_empty),
		.fq_pop       (fq_pop),
		.fq_sum       (fq_sum_out),
		.fq_peak      (fq_peak_out),
		.fq_len       (fq_len_out),
		.empty        (empty),
		.pop          (pop),
		.rms_level    (rms_level),
		.peak_level   (peak_level),
		.frame_length (frame_length)
	);

endmodule

### bench/tb_frame_rms_peak_meter.sv
module tb_frame_rms_peak_meter;
	timeunit 1ns;
	timeprecision 1ps;

	import frpm_pkg::*;

	// frame cap used by the instance below; the predictor closes frames at the same count
	localparam int FRAME_CAP = MAX_FRAME_DEF;

	// cycles with no transaction on either side before the run is called hung
	localparam int HANG_LIMIT = 4000;

	// quiet cycles after the last expected result, long enough for one full back-end pass
	localparam int DRAIN_CYCLES = 200;

	// idle chance per cycle, in percent, on both sides
	localparam int IDLE_PCT = 23;

	// random stream length, in samples
	localparam int RANDOM_SAMPLES = 700;

	// length of the all-max-magnitude frame
	localparam int FULL_SCALE_LEN = 32;

	typedef struct {
		logic [RMS_W-1:0]  rms;
		logic [PEAK_W-1:0] peak;
		logic [LEN_W-1:0]  len;
	} frame_levels_t;

	// Level scoreboard: runs its own copy of the accumulator state, predicts the
	// levels of every frame as it closes, and checks popped results in order.
	class level_scoreboard;
		longint unsigned sum_of_squares;
		int unsigned     peak_mag;
		int unsigned     sample_count;
		frame_levels_t   expected_levels[$];
		int unsigned     errors;

		function new();
			sum_of_squares = 0;
			peak_mag       = 0;
			sample_count   = 0;
			errors         = 0;
		endfunction

		// floor of the square root; the root never exceeds 2^23
		function longint unsigned floor_sqrt(longint unsigned radicand);
			longint unsigned root;
			longint unsigned trial;
			root = 0;
			for (int b = RMS_W - 1; b >= 0; b--) begin
				trial = root | (64'd1 << b);
				if (trial * trial <= radicand)
					root = trial;
			end
			return root;
		endfunction

		function int pending();
			return expected_levels.size();
		endfunction

		// one accepted sample transaction
		function void note_sample(logic [SAMPLE_W-1:0] smp, logic last);
			int unsigned     mag;
			longint unsigned mean_sq;
			frame_levels_t   lv;
			// -32768 gives 32768, not a wrapped value
			mag = smp[SAMPLE_W-1] ? (32'h10000 - 32'(smp)) : 32'(smp);
			sum_of_squares += longint'(mag) * longint'(mag);
			if (mag > peak_mag)
				peak_mag = mag;
			sample_count++;
			if (!last && sample_count < FRAME_CAP)
				return;
			mean_sq = (sum_of_squares << FRAC_SHIFT) / longint'(sample_count);
			lv.rms  = RMS_W'(floor_sqrt(mean_sq));
			lv.peak = PEAK_W'(peak_mag);
			lv.len  = LEN_W'(sample_count);
			expected_levels.push_back(lv);
			sum_of_squares = 0;
			peak_mag       = 0;
			sample_count   = 0;
		endfunction

		// one accepted result transaction
		function void check_levels(logic [RMS_W-1:0] rms, logic [PEAK_W-1:0] peak,
			logic [LEN_W-1:0] len);
			frame_levels_t lv;
			if (expected_levels.size() == 0) begin
				$error("unexpected result: rms_level %0d peak_level %0d frame_length %0d",
					rms, peak, len);
				errors++;
				return;
			end
			lv = expected_levels.pop_front();
			if (rms !== lv.rms) begin
				$error("rms_level: expected %0d, got %0d", lv.rms, rms);
				errors++;
			end
			if (peak !== lv.peak) begin
				$error("peak_level: expected %0d, got %0d", lv.peak, peak);
				errors++;
			end
			if (len !== lv.len) begin
				$error("frame_length: expected %0d, got %0d", lv.len, len);
				errors++;
			end
		endfunction
	endclass

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       push = 1'b0;
	logic                       full;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       frame_end = 1'b0;
	logic                       empty;
	logic                       pop = 1'b0;
	logic [RMS_W-1:0]           rms_level;
	logic [PEAK_W-1:0]          peak_level;
	logic [LEN_W-1:0]           frame_length;

	// set during the steady stretch: neither side idles
	bit no_gaps = 1'b0;

	level_scoreboard levels_sb = new();

	frame_rms_peak_meter #(
		.MAX_FRAME(FRAME_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.sample(sample),
		.frame_end(frame_end),
		.empty(empty),
		.pop(pop),
		.rms_level(rms_level),
		.peak_level(peak_level),
		.frame_length(frame_length)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Push one sample. Random idle cycles come first, then push stays up until the
	// transaction goes through. The scoreboard is told from this process, so a
	// closing sample is always on record before anyone looks at the pending count.
	task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic last);
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			push      <= 1'b0;
			sample    <= SAMPLE_W'($urandom);
			frame_end <= 1'($urandom);
			@(posedge clk);
		end
		push      <= 1'b1;
		sample    <= smp;
		frame_end <= last;
		@(posedge clk);
		while (full)
			@(posedge clk);
		levels_sb.note_sample(smp, last);
	endtask

	// sender backs off until every closed frame has been popped
	task automatic wait_for_levels_drained();
		push <= 1'b0;
		while (levels_sb.pending() != 0)
			@(posedge clk);
	endtask

	// sample mix: extremes often, small magnitudes of either sign, and full random
	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [SAMPLE_W-1:0] v;
		case ($urandom_range(9))
			0: v = 16'h8000;
			1: v = 16'h7FFF;
			2: v = 16'h0000;
			3: v = 16'h8001;
			4, 5: begin
				v = SAMPLE_W'($urandom_range(255));
				if ($urandom_range(1))
					v = -v;
			end
			default: v = SAMPLE_W'($urandom);
		endcase
		return v;
	endfunction

	// frame lengths: mostly short so the back end gets crowded and full shows up
	function automatic int pick_frame_len();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(8, 1);
		else if (r < 90)
			return $urandom_range(60, 9);
		return $urandom_range(300, 61);
	endfunction

	// result side: pop is redrawn every cycle; a result counts at the edge where
	// pop and !empty were both up before the edge
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty)
				levels_sb.check_levels(rms_level, peak_level, frame_length);
			pop <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// hang detector: counts cycles with no transaction on either port
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// main stimulus
	initial begin
		int  sent;
		int  len;
		bit  noisy;
		bit  paused;
		logic last;
		sent   = 0;
		paused = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single-sample frames at the extremes; -32768 must read back as 32768
		push_sample(16'h7FFF, 1'b1);
		push_sample(16'h8000, 1'b1);
		push_sample(16'h0000, 1'b1);
		push_sample(16'hFFFF, 1'b1);
		push_sample(16'h0001, 1'b1);
		// mixed extremes in one frame
		push_sample(16'h7FFF, 1'b0);
		push_sample(16'h8000, 1'b0);
		push_sample(16'h0000, 1'b0);
		push_sample(16'h8001, 1'b1);
		// equal magnitudes of both signs
		push_sample(16'd100, 1'b0);
		push_sample(-16'sd100, 1'b0);
		push_sample(16'd100, 1'b0);
		push_sample(-16'sd100, 1'b1);
		// RMS with a fraction that has to be floored
		push_sample(16'd1, 1'b0);
		push_sample(16'd2, 1'b0);
		push_sample(16'd3, 1'b0);
		push_sample(16'd4, 1'b0);
		push_sample(16'd5, 1'b1);

		// Full-scale frame, every sample at -32768: the RMS lands on its largest value,
		// 32768.0, which is 2^23 in the 24-bit rms_level with 8 fraction bits.
		wait_for_levels_drained();
		for (int i = 0; i < FULL_SCALE_LEN; i++)
			push_sample(16'h8000, 1'(i == FULL_SCALE_LEN - 1));

		// random frames; a few have frame_end scattered at random instead
		while (sent < RANDOM_SAMPLES) begin
			len   = pick_frame_len();
			noisy = ($urandom_range(9) == 0);
			for (int i = 0; i < len; i++) begin
				no_gaps = (sent >= 300 && sent < 480);
				last = noisy ? ($urandom_range(3) == 0) : (i == len - 1);
				push_sample(pick_sample(), last);
				sent++;
			end
			if (!paused && sent >= 500) begin
				wait_for_levels_drained();
				paused = 1'b1;
			end
		end
		no_gaps = 1'b0;
		// close whatever a noisy frame may have left open
		push_sample(pick_sample(), 1'b1);
		push <= 1'b0;

		while (levels_sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (levels_sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

### sim.f
rtl/frpm_pkg.sv
rtl/frpm_front.sv
rtl/frpm_fifo.sv
rtl/frpm_back.sv
rtl/frame_rms_peak_meter.sv
bench/tb_frame_rms_peak_meter.sv
